FILE: rtl/m8d16_pkg.sv
// m8d16_pkg: types and constants for the 8x8 multiply / 16-by-8 divide unit.
// Shared by m8d16_datapath and mul8_div16_math_unit; depends on nothing.
`default_nettype none

package m8d16_pkg;

   localparam logic       CMD_MUL           = 1'b0;
   localparam logic       CMD_DIV           = 1'b1;
   localparam logic [3:0] MUL_STEP_LAST     = 4'd7;
   localparam logic [3:0] DIV_STEP_LAST     = 4'd15;
   localparam logic [15:0] DIV_ZERO_QUOTIENT = 16'hFFFF;

   typedef struct packed {
      logic        command;
      logic [7:0]  multiplicand;
      logic [15:0] dividend_in;
      logic [7:0]  right_operand;
   } m8d16_req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic [15:0] remainder_value;
   } m8d16_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic is_div;
   } m8d16_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_FINISH
   } m8d16_state_type;

endpackage

`default_nettype wire

FILE: rtl/m8d16_datapath.sv
// m8d16_datapath: operand registers around one shared 9-bit adder, used for
// shift-add multiply and restoring divide. Depends on m8d16_pkg.
`default_nettype none

module m8d16_datapath (
   input  wire                      clock,
   input  wire m8d16_pkg::m8d16_ctrl_type ctrl,
   input  wire m8d16_pkg::m8d16_req_type  req,
   output logic [7:0]               part,
   output logic [15:0]              word
);
   import m8d16_pkg::*;

   logic [7:0]  part_ff, part_in;
   logic [15:0] word_ff, word_in;
   logic [7:0]  opnd_ff, opnd_in;
   logic [8:0]  add_a, add_b;
   logic        add_cin;
   logic [9:0]  add_sum;
   logic [8:0]  shifted;

   // shared adder
   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {9'd0, add_cin};
   assign shifted = {part_ff, word_ff[15]};

   always_comb begin
      if (ctrl.is_div) begin
         add_a   = shifted;
         add_b   = ~{1'b0, opnd_ff};
         add_cin = 1'b1;
      end else begin
         add_a   = {1'b0, part_ff};
         add_b   = word_ff[0] ? {1'b0, opnd_ff} : 9'd0;
         add_cin = 1'b0;
      end
   end

   always_comb begin
      part_in = part_ff;
      word_in = word_ff;
      opnd_in = opnd_ff;
      if (ctrl.load) begin
         part_in = 8'd0;
         if (req.command == CMD_DIV) begin
            word_in = req.dividend_in;
            opnd_in = req.right_operand;
         end else begin
            word_in = {8'd0, req.right_operand};
            opnd_in = req.multiplicand;
         end
      end else if (ctrl.step) begin
         if (ctrl.is_div) begin
            // carry out means no borrow: shifted >= divisor
            part_in = add_sum[9] ? add_sum[7:0] : shifted[7:0];
            word_in = {word_ff[14:0], add_sum[9]};
         end else begin
            part_in = add_sum[8:1];
            word_in = {8'd0, add_sum[0], word_ff[7:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      word_ff <= word_in;
      opnd_ff <= opnd_in;
   end

   assign part = part_ff;
   assign word = word_ff;

endmodule

`default_nettype wire

FILE: rtl/mul8_div16_math_unit.sv
// A multiply steps the shared 9-bit adder for each multiplier bit and a divide
// for each quotient bit, one bit per cycle; a divide by zero takes no steps.
// No new transaction is taken while one is in progress; the next one is taken
// once the previous result is written, even while it still waits in rsp_data.
// Reset (synchronous, active high) clears the sequencer, the output valid and
// the stored remainder. Depends on m8d16_pkg and m8d16_datapath.
`default_nettype none

module mul8_div16_math_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire m8d16_pkg::m8d16_req_type req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output m8d16_pkg::m8d16_rsp_type     rsp_data
);
   import m8d16_pkg::*;

   m8d16_state_type state_ff, state_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            is_div_ff, is_div_in;
   logic            div_zero_ff, div_zero_in;
   logic            rsp_valid_ff, rsp_valid_in;
   m8d16_rsp_type   rsp_data_ff, rsp_data_in;
   logic [15:0]     remainder_ff, remainder_in;

   m8d16_ctrl_type  ctrl;
   logic            out_free;
   logic            finish_write;
   logic [3:0]      step_last;
   logic [7:0]      dp_part;
   logic [15:0]     dp_word;
   logic [15:0]     new_result;
   logic [15:0]     new_remainder;

   // output register is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_last = is_div_ff ? DIV_STEP_LAST : MUL_STEP_LAST;

   m8d16_datapath u_datapath (
      .clock (clock),
      .ctrl  (ctrl),
      .req   (req_data),
      .part  (dp_part),
      .word  (dp_word)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (div_zero_ff || cnt_ff == step_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl         = '0;
      req_stall    = 1'b1;
      finish_write = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctrl.load   = req_valid;
            ctrl.is_div = req_data.command == CMD_DIV;
         end
         ST_BUSY: begin
            ctrl.step   = !div_zero_ff;
            ctrl.is_div = is_div_ff;
         end
         ST_FINISH: begin
            ctrl.is_div  = is_div_ff;
            finish_write = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // result selection; on divide by zero the datapath never stepped,
   // so its word still holds the dividend
   always_comb begin
      if (!is_div_ff) begin
         new_result    = {dp_part, dp_word[7:0]};
         new_remainder = remainder_ff;
      end else if (div_zero_ff) begin
         new_result    = DIV_ZERO_QUOTIENT;
         new_remainder = dp_word;
      end else begin
         new_result    = dp_word;
         new_remainder = {8'd0, dp_part};
      end
   end

   always_comb begin
      cnt_in       = cnt_ff;
      is_div_in    = is_div_ff;
      div_zero_in  = div_zero_ff;
      rsp_data_in  = rsp_data_ff;
      remainder_in = remainder_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.load) begin
         cnt_in      = 4'd0;
         is_div_in   = req_data.command == CMD_DIV;
         div_zero_in = (req_data.command == CMD_DIV) && (req_data.right_operand == 8'd0);
      end else if (ctrl.step) begin
         cnt_in = cnt_ff + 4'd1;
      end
      if (finish_write) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.result_value    = new_result;
         rsp_data_in.remainder_value = new_remainder;
         remainder_in                = new_remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         is_div_ff    <= 1'b0;
         div_zero_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         remainder_ff <= 16'd0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         is_div_ff    <= is_div_in;
         div_zero_ff  <= div_zero_in;
         rsp_valid_ff <= rsp_valid_in;
         remainder_ff <= remainder_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a result appears only out of the finishing state
   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid rose outside finish");

   // a multiply never runs past eight steps
   a_mul_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUSY && !is_div_ff) |-> (cnt_ff[3] == 1'b0))
      else $error("multiply step count overrun");

   // a multiply leaves the stored remainder alone
   a_mul_keeps_remainder: assert property (@(posedge clock) disable iff (reset)
      (finish_write && !is_div_ff) |=> $stable(remainder_ff))
      else $error("multiply changed stored remainder");

   // the reported remainder is the stored one
   a_rsp_remainder_match: assert property (@(posedge clock) disable iff (reset)
      finish_write |=> (rsp_data_ff.remainder_value == remainder_ff))
      else $error("reported remainder differs from stored");
`endif

endmodule

`default_nettype wire
